// ===== design/vcdf_pkg.sv =====
// Shared constants, codes and character tables of the VCD change record formatter.
package vcdf_pkg;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_ROLLOVER = 1'b0;
  localparam logic [15:0] ROLLOVER_RESET = 16'hFFFF;

  // Printable times stay at or below this limit, which fits in TIME_BITS bits.
  localparam logic [63:0] TIME_LIMIT = 64'd18000000000;
  localparam int unsigned TIME_BITS = 35;
  localparam int unsigned CONV_CNT_W = $clog2(TIME_BITS + 1);
  localparam int unsigned BIT_CNT_W = 4;

  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE = 8'h31;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_B = 8'h62;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  localparam logic [2:0] TAIL_LAST = 3'd5;

  // Trailer of every record: space, percent, CR, LF, CR, LF.
  function automatic logic [7:0] tail_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CHAR_SPACE;
      3'd1:    ch = CHAR_PERCENT;
      3'd2:    ch = CHAR_CR;
      3'd3:    ch = CHAR_LF;
      3'd4:    ch = CHAR_CR;
      default: ch = CHAR_LF;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/vcd_change_record_formatter.sv =====
// Top level of the VCD change record formatter: time base, decimal conversion, text output.
// Processing: an accepted sample passes through the time calculation, the range check,
// the 35 steps of the shift-and-add-3 conversion unit, then the character output states;
// leading zero digits and leading zero value bits are dropped without any output.
// A time above the limit skips the conversion and prints "-1".
// A new sample is accepted only once the last character of the current record is loaded.
// Reset (rst_ni low, asynchronous) clears the time base, sets the rollover marker to 65535
// and empties the output register.
module vcd_change_record_formatter #(
  parameter int unsigned DECIMAL_DIGITS = 12,
  parameter int unsigned BASE_BITS = 36
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    sample_value_i,
  input  logic [15:0]                   time_offset_i,
  input  logic                          end_of_dump_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    char_out_o,
  output logic                          record_done_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vcdf_pkg::ADDR_W-1:0]   paddr,
  input  logic [vcdf_pkg::DATA_W-1:0]   pwdata,
  output logic [vcdf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import vcdf_pkg::*;

  localparam int unsigned SUM_W = BASE_BITS + 1;
  localparam int unsigned BCD_W = 4 * DECIMAL_DIGITS;
  localparam int unsigned DIG_CNT_W = $clog2(DECIMAL_DIGITS + 1);
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(TIME_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_CHECK, S_CONV, S_HASH, S_MINUS, S_ONE,
    S_DIG, S_CR, S_LF, S_B, S_BIT, S_TAIL
  } state_e;

  state_e                 state_q, state_d;
  logic [BASE_BITS-1:0]   base_q, base_d;
  logic [15:0]            marker_q, marker_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             char_q, char_d;
  logic                   done_q, done_d;

  logic [7:0]             val_q, val_d;
  logic [15:0]            off_q, off_d;
  logic                   last_q, last_d;
  logic [SUM_W-1:0]       t_q, t_d;
  logic [TIME_BITS-1:0]   bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [CONV_CNT_W-1:0]  conv_cnt_q, conv_cnt_d;
  logic [DIG_CNT_W-1:0]   dig_left_q, dig_left_d;
  logic [BIT_CNT_W-1:0]   bit_left_q, bit_left_d;
  logic [2:0]             tail_idx_q, tail_idx_d;
  logic                   seen_q, seen_d;
  logic                   ovf_q, ovf_d;

  logic                   can_load;
  logic [SUM_W-1:0]       sum;
  logic [BASE_BITS-1:0]   sat_base;
  logic [BCD_W-1:0]       bcd_adj;
  logic [3:0]             top_digit;
  logic                   cfg_write;

  assign can_load  = !out_valid_q || out_ready_i;
  assign sum       = {1'b0, base_q} + SUM_W'(off_q);
  assign sat_base  = sum[BASE_BITS] ? '1 : sum[BASE_BITS-1:0];
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_ROLLOVER);

  // Shift-and-add-3 correction, applied to every BCD digit in parallel.
  always_comb begin
    for (int i = 0; i < DECIMAL_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                      : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    marker_d    = marker_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    done_d      = done_q;
    val_d       = val_q;
    off_d       = off_q;
    last_d      = last_q;
    t_d         = t_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    conv_cnt_d  = conv_cnt_q;
    dig_left_d  = dig_left_q;
    bit_left_d  = bit_left_q;
    tail_idx_d  = tail_idx_q;
    seen_d      = seen_q;
    ovf_d       = ovf_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_write) begin
      marker_d = pwdata[15:0];
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d   = sample_value_i;
          off_d   = time_offset_i;
          last_d  = end_of_dump_i;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (base_q == '0) begin
          base_d = BASE_BITS'(off_q);
          t_d    = SUM_W'(off_q);
        end else if (off_q == marker_q) begin
          base_d = sat_base;
          t_d    = {1'b0, sat_base};
        end else begin
          t_d = sum;
        end
        if (last_q) begin
          base_d = '0;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        ovf_d      = t_q > LIMIT;
        bin_d      = t_q[TIME_BITS-1:0];
        bcd_d      = '0;
        conv_cnt_d = CONV_CNT_W'(TIME_BITS);
        state_d    = (t_q > LIMIT) ? S_HASH : S_CONV;
      end
      S_CONV: begin
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        conv_cnt_d     = conv_cnt_q - 1'b1;
        if (conv_cnt_q == CONV_CNT_W'(1)) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_HASH;
          done_d      = 1'b0;
          dig_left_d  = DIG_CNT_W'(DECIMAL_DIGITS);
          seen_d      = 1'b0;
          state_d     = ovf_q ? S_MINUS : S_DIG;
        end
      end
      S_MINUS: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          done_d      = 1'b0;
          state_d     = S_ONE;
        end
      end
      S_ONE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_ONE;
          done_d      = 1'b0;
          state_d     = S_CR;
        end
      end
      S_DIG: begin
        // Leading zero digits are dropped, but the last digit always prints.
        if (!seen_q && (top_digit == 4'd0) && (dig_left_q != DIG_CNT_W'(1))) begin
          bcd_d      = bcd_q << 4;
          dig_left_d = dig_left_q - 1'b1;
        end else if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_ZERO + 8'(top_digit);
          done_d      = 1'b0;
          seen_d      = 1'b1;
          bcd_d       = bcd_q << 4;
          dig_left_d  = dig_left_q - 1'b1;
          if (dig_left_q == DIG_CNT_W'(1)) begin
            state_d = S_CR;
          end
        end
      end
      S_CR: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_CR;
          done_d      = 1'b0;
          state_d     = S_LF;
        end
      end
      S_LF: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_LF;
          done_d      = 1'b0;
          state_d     = S_B;
        end
      end
      S_B: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_B;
          done_d      = 1'b0;
          bit_left_d  = BIT_CNT_W'(8);
          seen_d      = 1'b0;
          state_d     = S_BIT;
        end
      end
      S_BIT: begin
        if (!seen_q && !val_q[7] && (bit_left_q != BIT_CNT_W'(1))) begin
          val_d      = val_q << 1;
          bit_left_d = bit_left_q - 1'b1;
        end else if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = val_q[7] ? CHAR_ONE : CHAR_ZERO;
          done_d      = 1'b0;
          seen_d      = 1'b1;
          val_d       = val_q << 1;
          bit_left_d  = bit_left_q - 1'b1;
          if (bit_left_q == BIT_CNT_W'(1)) begin
            tail_idx_d = 3'd0;
            state_d    = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = tail_char(tail_idx_q);
          done_d      = (tail_idx_q == TAIL_LAST);
          tail_idx_d  = tail_idx_q + 3'd1;
          if (tail_idx_q == TAIL_LAST) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      marker_q    <= ROLLOVER_RESET;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      marker_q    <= marker_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    off_q      <= off_d;
    last_q     <= last_d;
    t_q        <= t_d;
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    conv_cnt_q <= conv_cnt_d;
    dig_left_q <= dig_left_d;
    bit_left_q <= bit_left_d;
    tail_idx_q <= tail_idx_d;
    seen_q     <= seen_d;
    ovf_q      <= ovf_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign char_out_o    = char_q;
  assign record_done_o = done_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[ADDR_W-1:2] == REG_ROLLOVER) ? DATA_W'(marker_q) : '0;

endmodule

// ===== design/vcdf_checker.sv =====
// Port-level assertions for the VCD change record formatter and their bind.
module vcdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] char_out_o,
  input logic       record_done_o
);
  import vcdf_pkg::*;

  // High while the next word on the output starts a new record.
  logic first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      first_q <= record_done_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_out_o)
                                    && $stable(record_done_o))
    else $error("output word changed while stalled");

  a_done_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_done_o |-> char_out_o == CHAR_LF)
    else $error("record does not end in LF");

  a_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q |-> char_out_o == CHAR_HASH && !record_done_o)
    else $error("record does not start with a hash");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample accepted while a record is in progress");

endmodule

bind vcd_change_record_formatter vcdf_checker u_vcdf_checker (.*);

// ===== tb/vcd_change_record_formatter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the VCD change record formatter with a built-in text predictor.

module vcd_change_record_formatter_tb;
  import vcdf_pkg::*;

  localparam int unsigned DIGITS = 12;
  localparam int unsigned BASE_W = 36;
  localparam logic [63:0] BASE_MAX = (64'd1 << BASE_W) - 64'd1;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 70;
  localparam logic [ADDR_W-1:0] ROLLOVER_ADDR = {REG_ROLLOVER, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ROLLOVER_ADDR ^ 3'b100;

  // Predicts the record text of each sample and checks the characters that come out.
  class change_record_board;
    logic [BASE_W-1:0] time_base;
    logic [15:0]       marker;
    logic [8:0]        expected_chars[$];  // {record_done, char}
    int                errors;

    function new();
      time_base = '0;
      marker = ROLLOVER_RESET;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void push_char(logic [7:0] ch);
      expected_chars.push_back({1'b0, ch});
    endfunction

    function void note_sample(logic [7:0] value, logic [15:0] offset, logic last);
      logic [63:0] abs_time;
      logic [63:0] sum;
      logic [3:0]  digit_q[$];
      logic        seen;
      if (time_base == '0) begin
        time_base = BASE_W'(offset);
        abs_time = 64'(offset);
      end else if (offset == marker) begin
        sum = 64'(time_base) + 64'(offset);
        time_base = (sum > BASE_MAX) ? BASE_MAX[BASE_W-1:0] : sum[BASE_W-1:0];
        abs_time = 64'(time_base);
      end else begin
        abs_time = 64'(time_base) + 64'(offset);
      end
      if (last) time_base = '0;

      push_char(CHAR_HASH);
      if (abs_time > TIME_LIMIT) begin
        push_char(CHAR_MINUS);
        push_char(CHAR_ONE);
      end else begin
        do begin
          digit_q.push_front(4'(abs_time % 64'd10));
          abs_time = abs_time / 64'd10;
        end while (abs_time != 0 && digit_q.size() < DIGITS);
        foreach (digit_q[k]) push_char(CHAR_ZERO + 8'(digit_q[k]));
      end
      push_char(CHAR_CR);
      push_char(CHAR_LF);
      push_char(CHAR_B);
      // Binary value without leading zeros; a zero value still prints one digit.
      seen = 1'b0;
      for (int k = 7; k >= 0; k--) begin
        if (value[k] || k == 0) seen = 1'b1;
        if (seen) push_char(value[k] ? CHAR_ONE : CHAR_ZERO);
      end
      push_char(CHAR_SPACE);
      push_char(CHAR_PERCENT);
      push_char(CHAR_CR);
      push_char(CHAR_LF);
      push_char(CHAR_CR);
      push_char(CHAR_LF);
      expected_chars[expected_chars.size()-1][8] = 1'b1;
    endfunction

    function void check_char(logic [7:0] ch, logic done);
      logic [8:0] exp_word;
      if (expected_chars.size() == 0) begin
        flag($sformatf("unexpected character %h, record_done %b", ch, done));
      end else begin
        exp_word = expected_chars.pop_front();
        if (exp_word != {done, ch})
          flag($sformatf("character mismatch: expected %h done %b, got %h done %b",
                         exp_word[7:0], exp_word[8], ch, done));
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        sample_value_i = '0;
  logic [15:0]       time_offset_i = '0;
  logic              end_of_dump_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        char_out_o;
  logic              record_done_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  change_record_board sb = new();
  bit                 in_gaps = 1'b1;
  bit                 out_gaps = 1'b1;
  int unsigned        cycle_count = 0;

  vcd_change_record_formatter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_value_i(sample_value_i),
    .time_offset_i (time_offset_i),
    .end_of_dump_i (end_of_dump_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_out_o    (char_out_o),
    .record_done_o (record_done_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("vcd_change_record_formatter_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_char(char_out_o, record_done_o);
      out_ready_i <= !out_gaps || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_sample(input logic [7:0] value, input logic [15:0] offset,
                             input logic last);
    while (in_gaps && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_value_i <= value;
    time_offset_i <= offset;
    end_of_dump_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(value, offset, last);
  endtask

  // Waits until every expected character has come out and the block has settled.
  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes a register, then reads the rollover marker back.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ROLLOVER_ADDR) sb.marker = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ROLLOVER_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== sb.marker)
      sb.flag($sformatf("rollover marker readback: expected %h, got %h",
                        sb.marker, prdata[15:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Rollover markers are frequent so that the time base keeps growing.
  function automatic logic [15:0] pick_offset();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return sb.marker;
    if (r < 38) return 16'h0000;
    if (r < 46) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  initial begin
    logic [15:0] marker_val;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Marker at its reset value.
    send_sample(8'h00, 16'd0, 1'b0);
    send_sample(8'hFF, 16'hFFFF, 1'b0);
    send_sample(8'h01, 16'hFFFF, 1'b0);
    send_sample(8'h80, 16'd0, 1'b0);
    send_sample(8'h55, 16'd12345, 1'b1);
    send_sample(8'hAA, 16'd0, 1'b0);
    send_sample(8'h01, 16'd1000, 1'b1);
    go_idle();

    // A zero marker: a zero offset on a zero base still takes the base.
    write_reg(ROLLOVER_ADDR, 16'h0000);
    send_sample(8'h02, 16'd0, 1'b0);
    send_sample(8'h07, 16'd7, 1'b0);
    send_sample(8'h40, 16'd0, 1'b0);
    send_sample(8'hFF, 16'hFFFF, 1'b1);
    go_idle();

    // A write past the register list must leave the marker alone.
    write_reg(UNUSED_ADDR, 16'($urandom_range(65535)));
    send_sample(8'h0F, 16'd300, 1'b0);
    send_sample(8'h10, 16'd0, 1'b1);
    go_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: marker_val = 16'hFFFF;
        1: marker_val = 16'h0000;
        3: marker_val = 16'h0001;
        default: marker_val = 16'($urandom_range(65535));
      endcase
      write_reg(ROLLOVER_ADDR, marker_val);
      in_gaps = (phase != 2);
      out_gaps = (phase != 2);
      repeat (20) send_sample(pick_value(), pick_offset(), $urandom_range(99) < 8);
      go_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
      $display("vcd_change_record_formatter_tb: clean");
    end else begin
      $display("vcd_change_record_formatter_tb: errors");
    end
    $finish;
  end

endmodule
